// ----- hw/rtl/srq_pkg.sv -----
// ---------------------------------------------------------------------------
// srq_pkg: shared types and constants for the sorted render queue
// Command and status codes, beat field widths and the compare result bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package srq_pkg;

   // fixed beat field widths
   localparam int CMD_W        = 2;
   localparam int TILE_ID_W    = 16;
   localparam int PLANE_W      = 8;
   localparam int STATUS_W     = 2;
   localparam int POSITION_W   = 6;
   localparam int OCCUPANCY_W  = 7;
   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_TDATA_W  = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // outcome of comparing the pending entry against one stored entry
   typedef struct packed {
      logic precedes;  // pending entry sorts strictly before stored entry
      logic id_match;  // ids are equal
   } cmp_result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/srq_order_cmp.sv -----
// ---------------------------------------------------------------------------
// srq_order_cmp: ordering and id compare unit
// Compares the pending entry with one stored entry; shared by every step of
// the table walk. Entry layout from the MSB: id, deferred, transparent, plane.
// ---------------------------------------------------------------------------
`default_nettype none

module srq_order_cmp
   import srq_pkg::*;
#(
   parameter int ID_BITS    = 16,
   parameter int PLANE_BITS = 8
) (
   input  wire logic [ID_BITS+PLANE_BITS+1:0] cand_entry,
   input  wire logic [ID_BITS+PLANE_BITS+1:0] store_entry,
   output cmp_result_type                     result
);

   logic [ID_BITS-1:0]    cand_id, store_id;
   logic                  cand_def, store_def;
   logic                  cand_trn, store_trn;
   logic [PLANE_BITS-1:0] cand_plane, store_plane;

   assign {cand_id, cand_def, cand_trn, cand_plane}     = cand_entry;
   assign {store_id, store_def, store_trn, store_plane} = store_entry;

   always_comb begin
      if (cand_def != store_def) begin
         result.precedes = !cand_def && store_def;
      end else if (cand_trn != store_trn) begin
         result.precedes = !cand_trn && store_trn;
      end else if (cand_trn) begin
         // transparent entries draw back to front
         result.precedes = cand_plane > store_plane;
      end else begin
         result.precedes = cand_plane < store_plane;
      end
      result.id_match = cand_id == store_id;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_render_queue.sv -----
// ---------------------------------------------------------------------------
// sorted_render_queue: sorted table of render entries
// Insert keeps the table ordered, remove deletes the first matching id and
// closes the gap, flush empties it. One response beat per request beat.
// ---------------------------------------------------------------------------
//
//   channel  dir  tdata                                       tuser
//   -------  ---  ------------------------------------------  -----------
//   req_     in   tile_id, deferred, transparent, plane        command
//   rsp_     out  position, occupancy                          status
//
// Sequencing: a request beat is taken only while the sequencer is idle. Insert
// walks entries 0..count, remove walks 0..count-1, one entry per cycle,
// set by the single read port of the entry memory. Flush, full, empty
// remove and unknown commands skip the walk. Every result then goes
// through ST_RESP into the response register that drives rsp_tvalid.
// Reset clears the sequencer, entry count and response valid; the entry
// memory is not cleared, and its contents past the count never affect a result.
// A stalled response does not block the next request: the new result waits
// in the sequencer until the response register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_render_queue
   import srq_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int ID_BITS    = 16,
   parameter int PLANE_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request: [15:0] tile_id, [16] deferred, [17] transparent, [25:18] plane
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // request: [1:0] command
   input  wire logic [CMD_W-1:0]       req_tuser,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // response: [5:0] position, [12:6] occupancy
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // response: [1:0] status
   output logic [STATUS_W-1:0]         rsp_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready
);

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int ENTRY_W = ID_BITS + PLANE_BITS + 2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,  // waiting for a request beat
      ST_WALK = 3'b010,  // stepping through the table, one entry a cycle
      ST_RESP = 3'b100   // result ready, waiting for the response register
   } state_type;

   // sequencer
   state_type      state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic           found_ff, found_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [ENTRY_W-1:0] cand_ff, cand_in;   // entry being inserted / id searched
   logic [ENTRY_W-1:0] carry_ff, carry_in; // entry displaced by the insert ripple
   logic [CNT_W-1:0] count_ff, count_in;

   // pending result
   status_type     res_status_ff, res_status_in;
   logic [IDX_W-1:0] res_pos_ff, res_pos_in;
   logic [CNT_W-1:0] res_occ_ff, res_occ_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_user_ff, rsp_user_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // entry memory
   logic [ENTRY_W-1:0] store_mem [CAPACITY];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   mem_raddr, mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic               mem_we;

   cmp_result_type cmp;
   logic           req_fire, rsp_load;
   logic           at_end, at_last;
   cmd_type        req_cmd;

   srq_order_cmp #(
      .ID_BITS    (ID_BITS),
      .PLANE_BITS (PLANE_BITS)
   ) u_cmp (
      .cand_entry  (cand_ff),
      .store_entry (rd_data_ff),
      .result      (cmp)
   );

   assign req_tready = state_ff == ST_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign req_cmd    = cmd_type'(req_tuser);
   assign rsp_load   = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);

   // insert walk ends on the slot just past the last entry;
   // remove walk ends on the last entry
   assign at_end  = CNT_W'(idx_ff) == count_ff;
   assign at_last = CNT_W'(idx_ff) == count_ff - 1'b1;

   // next read runs one entry ahead of the entry being evaluated
   assign mem_raddr = (state_ff == ST_WALK) ? idx_ff + 1'b1 : '0;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      cand_in       = cand_ff;
      carry_in      = carry_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_occ_in    = res_occ_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = cand_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_cmd;
               idx_in   = '0;
               found_in = 1'b0;
               pos_in   = '0;
               cand_in  = {ID_BITS'(req_tdata[TILE_ID_W-1:0]),
                           req_tdata[TILE_ID_W],
                           req_tdata[TILE_ID_W+1],
                           PLANE_BITS'(req_tdata[TILE_ID_W+2 +: PLANE_W])};
               res_pos_in = '0;
               res_occ_in = count_ff;
               state_in   = ST_RESP;
               case (req_cmd)
                  CMD_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_NOT_FOUND;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  CMD_FLUSH: begin
                     count_in      = '0;
                     res_occ_in    = '0;
                     res_status_in = STATUS_DONE;
                  end
                  default: begin
                     res_status_in = STATUS_DONE;
                  end
               endcase
            end
         end

         ST_WALK: begin
            idx_in = idx_ff + 1'b1;
            if (cmd_ff == CMD_INSERT) begin
               // ripple insert: from the slot on, every entry moves up by one
               if (found_ff) begin
                  mem_we    = 1'b1;
                  mem_wdata = carry_ff;
                  carry_in  = rd_data_ff;
               end else if (at_end || cmp.precedes) begin
                  mem_we    = 1'b1;
                  mem_wdata = cand_ff;
                  carry_in  = rd_data_ff;
                  found_in  = 1'b1;
                  pos_in    = idx_ff;
               end
               if (at_end) begin
                  count_in      = count_ff + 1'b1;
                  res_status_in = STATUS_DONE;
                  res_pos_in    = found_ff ? pos_ff : idx_ff;
                  res_occ_in    = count_ff + 1'b1;
                  state_in      = ST_RESP;
               end
            end else begin
               // remove: after the match every entry moves down by one
               if (found_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = idx_ff - 1'b1;
                  mem_wdata = rd_data_ff;
               end else if (cmp.id_match) begin
                  found_in = 1'b1;
                  pos_in   = idx_ff;
               end
               if (at_last) begin
                  state_in = ST_RESP;
                  if (found_ff || cmp.id_match) begin
                     count_in      = count_ff - 1'b1;
                     res_status_in = STATUS_DONE;
                     res_pos_in    = found_ff ? pos_ff : idx_ff;
                     res_occ_in    = count_ff - 1'b1;
                  end else begin
                     res_status_in = STATUS_NOT_FOUND;
                     res_pos_in    = '0;
                     res_occ_in    = count_ff;
                  end
               end
            end
         end

         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = res_status_ff;
         rsp_data_in  = RSP_TDATA_W'({OCCUPANCY_W'(res_occ_ff), POSITION_W'(res_pos_ff)});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      pos_ff        <= pos_in;
      cand_ff       <= cand_in;
      carry_ff      <= carry_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_occ_ff    <= res_occ_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= store_mem[mem_raddr];
   end

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_write_only_walking: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == ST_WALK)
      else $error("entry memory written outside the walk");

   a_walk_in_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> CNT_W'(idx_ff) <= count_ff)
      else $error("walk index beyond entry count");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("request taken without leaving idle");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response raised without a pending result");

endmodule

`default_nettype wire
